// ----- rtl/rff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_pkg
// Shared types and constants of the rotated frame store fill engine.
// ----------------------------------------------------------------------------
package rff_pkg;

  // field widths
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ROT_W   = 2;
  localparam int unsigned PROD_W  = 2 * DIM_W;
  localparam int unsigned SUM_W   = COORD_W + 1;
  localparam int unsigned MAP_W   = DIM_W + 2;

  // default store geometry
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SCREEN = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ROTATION = 3'd0;
  localparam logic [2:0] REG_DEV_W    = 3'd1;
  localparam logic [2:0] REG_DEV_H    = 3'd2;
  localparam logic [2:0] REG_LOG_W    = 3'd3;
  localparam logic [2:0] REG_LOG_H    = 3'd4;

  // configuration seen by the datapath
  typedef struct packed {
    logic [ROT_W-1:0] rotation;
    logic [DIM_W-1:0] dev_w;
    logic [DIM_W-1:0] dev_h;
    logic [DIM_W-1:0] log_w;
    logic [DIM_W-1:0] log_h;
  } cfg_t;

  // one command item
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COLOR_W-1:0] fill_color;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the item
    logic start;  // set up the walk from the clipped bounds
    logic walk;   // issue the current point and advance
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;  // clipped area holds no pixel
    logic last;   // current point is the final one
    logic busy;   // pipeline still holds an access
  } status_t;

endpackage

// ----- rtl/rotated_framebuffer_fill_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_framebuffer_fill_engine
// Rotated 16-bit frame store with set, get, rectangle fill and screen fill.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command per beat: tuser = kind, tdata = x_pos, y_pos,
//   rect_width, rect_height, fill_color. m_axis returns one beat per command:
//   tdata = read_color, tuser = read_valid (set only for a get that hit).
//   the apb port holds rotation and device/logical sizes; write it only
//   while no command is in flight. size writes saturate into 1..max.
//   one command is worked at a time. after accept the sequencer passes load
//   and start, walks the clipped area (the device area for a screen fill;
//   an empty area skips the walk), waits for the store pipeline to drain
//   and hands the result to the output register before it takes the next
//   command. the walk counters issue one pixel per cycle into a three stage
//   map, multiply and store pipeline, and the store has one port.
//   a finished result waits in the output register while m_axis stalls; the
//   engine takes the next command meanwhile and holds its result until the
//   register frees. reset restores the default sizes and rotation zero and
//   leaves the store contents undefined.
// ----------------------------------------------------------------------------
module rotated_framebuffer_fill_engine #(
  parameter int unsigned MAX_WIDTH  = rff_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rff_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_pos[15:0], y_pos[31:16], rect_width[47:32], rect_height[63:48],
  // fill_color[79:64]
  input  logic [79:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_color[15:0]
  output logic [15:0] m_axis_tdata,
  // read_valid[0]
  output logic [0:0]  m_axis_tuser,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rff_pkg::*;

  localparam int unsigned DEF_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int unsigned DEF_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  cfg_t               cfg_q;
  item_t              item;
  cmd_t               cmd;
  status_t            status;
  logic               cfg_wr;
  logic [2:0]         reg_idx;
  logic [DIM_W-1:0]   wval;
  logic               out_free, out_load;
  logic [COLOR_W-1:0] dp_color;
  logic               dp_valid;
  logic               m_valid_q;
  logic [COLOR_W-1:0] m_color_q;
  logic               m_flag_q;

  // saturate a size into 1..lim
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > lim) begin
      r = DIM_W'(lim);
    end
    return r;
  endfunction

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign wval    = pwdata[DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation <= '0;
      cfg_q.dev_w    <= DIM_W'(DEF_W);
      cfg_q.dev_h    <= DIM_W'(DEF_H);
      cfg_q.log_w    <= DIM_W'(DEF_W);
      cfg_q.log_h    <= DIM_W'(DEF_H);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROTATION: cfg_q.rotation <= pwdata[ROT_W-1:0];
        REG_DEV_W:    cfg_q.dev_w    <= clamp_dim(wval, MAX_WIDTH);
        REG_DEV_H:    cfg_q.dev_h    <= clamp_dim(wval, MAX_HEIGHT);
        REG_LOG_W:    cfg_q.log_w    <= clamp_dim(wval, MAX_WIDTH);
        REG_LOG_H:    cfg_q.log_h    <= clamp_dim(wval, MAX_HEIGHT);
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_ROTATION: prdata = 32'(cfg_q.rotation);
      REG_DEV_W:    prdata = 32'(cfg_q.dev_w);
      REG_DEV_H:    prdata = 32'(cfg_q.dev_h);
      REG_LOG_W:    prdata = 32'(cfg_q.log_w);
      REG_LOG_H:    prdata = 32'(cfg_q.log_h);
      default:      prdata = '0;
    endcase
  end

  // unpack the command beat
  assign item.kind        = s_axis_tuser;
  assign item.x_pos       = s_axis_tdata[15:0];
  assign item.y_pos       = s_axis_tdata[31:16];
  assign item.rect_width  = s_axis_tdata[47:32];
  assign item.rect_height = s_axis_tdata[63:48];
  assign item.fill_color  = s_axis_tdata[79:64];

  rff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  rff_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .cmd_i        (cmd),
    .status_o     (status),
    .read_color_o (dp_color),
    .read_valid_o (dp_valid)
  );

  // output register
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_color_q <= dp_color;
      m_flag_q  <= dp_valid;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_color_q;
  assign m_axis_tuser[0] = m_flag_q;

endmodule

// ----- rtl/rff_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_ctrl
// Sequencer: takes one command, walks its pixels, waits for the store
// pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module rff_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_free_i,
  output logic             out_load_o,
  output rff_pkg::cmd_t    cmd_o,
  input  rff_pkg::status_t status_i
);
  import rff_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.start = 1'b1;
        state_d     = status_i.empty ? ST_FINISH : ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status_i.busy && out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/rff_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rff_datapath
// Item capture, clipping, pixel walk counters, rotation mapping, address
// multiply and the frame store with its registered read port.
// ----------------------------------------------------------------------------
module rff_datapath #(
  parameter int unsigned MAX_WIDTH  = rff_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rff_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rff_pkg::cfg_t                cfg_i,
  input  rff_pkg::item_t               item_i,
  input  rff_pkg::cmd_t                cmd_i,
  output rff_pkg::status_t             status_o,
  output logic [rff_pkg::COLOR_W-1:0]  read_color_o,
  output logic                         read_valid_o
);
  import rff_pkg::*;

  localparam int unsigned STORE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;

  // captured item
  item_t item_q;

  // walk counters and bounds
  logic [DIM_W-1:0] cx_q, cy_q, x0_q, ex_q, ey_q;

  // pipeline registers
  logic              s1_v_q, s2_v_q;
  logic [DIM_W-1:0]  s1_dx_q, s1_dy_q;
  logic [PROD_W-1:0] s2_addr_q;

  // store and read port
  logic [COLOR_W-1:0] mem [STORE];
  logic [COLOR_W-1:0] rd_data_q;
  logic               rd_hit_q;

  // clipping
  logic                      is_pixel, is_screen, is_read;
  logic signed [SUM_W-1:0]   xv, yv, wv, hv, xs, ys, xe, ye, x0, y0, lw, lh;
  logic                      empty;

  // mapping
  logic signed [MAP_W-1:0]   cxs, cys, dwm1, dhm1, dws, dhs, dx, dy;
  logic                      map_ok;
  logic                      adv_last_x;
  logic [PROD_W-1:0]         addr_d;
  logic [ADDR_W-1:0]         mem_idx;

  assign is_pixel  = (item_q.kind == KIND_SET) || (item_q.kind == KIND_GET);
  assign is_screen = (item_q.kind == KIND_SCREEN);
  assign is_read   = (item_q.kind == KIND_GET);

  // capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // clip the command to the logical area, a pixel is a one by one rectangle; a screen fill covers the device area
  always_comb begin
    xv = SUM_W'($signed(item_q.x_pos));
    yv = SUM_W'($signed(item_q.y_pos));
    wv = is_pixel ? SUM_W'(1) : SUM_W'($signed(item_q.rect_width));
    hv = is_pixel ? SUM_W'(1) : SUM_W'($signed(item_q.rect_height));
    lw = $signed({{(SUM_W-DIM_W){1'b0}}, cfg_i.log_w});
    lh = $signed({{(SUM_W-DIM_W){1'b0}}, cfg_i.log_h});
    xs = xv + wv;
    ys = yv + hv;
    if (is_screen) begin
      x0    = '0;
      y0    = '0;
      xe    = $signed({{(SUM_W-DIM_W){1'b0}}, cfg_i.dev_w});
      ye    = $signed({{(SUM_W-DIM_W){1'b0}}, cfg_i.dev_h});
      empty = 1'b0;
    end else begin
      x0    = (xv < 0) ? '0 : xv;
      y0    = (yv < 0) ? '0 : yv;
      xe    = (xs > lw) ? lw : xs;
      ye    = (ys > lh) ? lh : ys;
      empty = (wv <= 0) || (hv <= 0) || (x0 >= xe) || (y0 >= ye);
    end
  end

  // walk counters, row by row
  assign adv_last_x = (cx_q == ex_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cx_q <= x0[DIM_W-1:0];
      cy_q <= y0[DIM_W-1:0];
      x0_q <= x0[DIM_W-1:0];
      ex_q <= DIM_W'(xe - SUM_W'(1));
      ey_q <= DIM_W'(ye - SUM_W'(1));
    end else if (cmd_i.walk) begin
      if (adv_last_x) begin
        cx_q <= x0_q;
        cy_q <= cy_q + DIM_W'(1);
      end else begin
        cx_q <= cx_q + DIM_W'(1);
      end
    end
  end

  // rotation mapping (none for a screen fill) and device bounds check
  always_comb begin
    cxs  = $signed({2'b00, cx_q});
    cys  = $signed({2'b00, cy_q});
    dws  = $signed({2'b00, cfg_i.dev_w});
    dhs  = $signed({2'b00, cfg_i.dev_h});
    dwm1 = dws - MAP_W'(1);
    dhm1 = dhs - MAP_W'(1);
    dx   = cxs;
    dy   = cys;
    if (!is_screen) begin
      case (cfg_i.rotation)
        2'd1: begin
          dx = dwm1 - cys;
          dy = cxs;
        end
        2'd2: begin
          dx = dwm1 - cxs;
          dy = dhm1 - cys;
        end
        2'd3: begin
          dx = cys;
          dy = dhm1 - cxs;
        end
        default: begin
          dx = cxs;
          dy = cys;
        end
      endcase
    end
    map_ok = (dx >= 0) && (dx < dws) && (dy >= 0) && (dy < dhs);
  end

  // stage one: mapped device point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.walk && map_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q <= dx[DIM_W-1:0];
    s1_dy_q <= dy[DIM_W-1:0];
  end

  // stage two: row-major address
  assign addr_d = s1_dy_q * cfg_i.dev_w + PROD_W'(s1_dx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q <= addr_d;
  end

  // frame store access
  assign mem_idx = ADDR_W'(s2_addr_q);

  always_ff @(posedge clk_i) begin
    if (s2_v_q && !is_read) begin
      mem[mem_idx] <= item_q.fill_color;
    end
    if (s2_v_q && is_read) begin
      rd_data_q <= mem[mem_idx];
    end
  end

  // read hit flag, cleared for each new command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      rd_hit_q <= 1'b0;
    end else if (s2_v_q && is_read) begin
      rd_hit_q <= 1'b1;
    end
  end

  // status and result
  assign status_o.empty = empty;
  assign status_o.last  = adv_last_x && (cy_q == ey_q);
  assign status_o.busy  = s1_v_q || s2_v_q;

  assign read_color_o = rd_hit_q ? rd_data_q : '0;
  assign read_valid_o = rd_hit_q;

endmodule
